FILE: rtl/cqf_pkg.sv
// Shared codes, widths and types for the circular queue FIFO.
package cqf_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 4;

	localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DEQ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	// Per-cell control: shift pulls the upper neighbor down, load captures the new word.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

FILE: rtl/cqf_cell.sv
// One storage cell of the queue chain.
module cqf_cell
	import cqf_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  word_t      upper_data,
	input  word_t      in_value,
	output word_t      data
);

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= upper_data;
		end else if (ctrl.load) begin
			data_q <= in_value;
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/circular_queue_fifo.sv
// Circular queue FIFO top level: a chain of word cells with a fill counter.
// Results are registered: a result appears on m_axis in the cycle after its request is accepted.
// Throughput: one request per cycle while m_axis_tready is high; the output register frees each cycle it is taken.
// Storage holds up to DEPTH-1 words in a row of cells; cell 0 is the head and a
// dequeue moves every word one cell toward it in the same cycle.
// Reset (arst_n low, asynchronous) empties the queue and drops any pending result.
module circular_queue_fifo
	import cqf_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] in_value
	input  logic [1:0]  s_axis_tuser,  // [1:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] out_value, [35:32] count, [39:36] zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	localparam int unsigned NCELL = DEPTH - 1;
	localparam int unsigned CW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int unsigned EXT_W = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [CW-1:0] FILL_MAX = CW'(DEPTH - 1);

	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          fill_nxt;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	word_t                  value_q;
	logic [COUNT_W-1:0]     count_q;

	logic                   accept;
	logic [ACTION_W-1:0]    action;
	word_t                  in_value;
	logic                   empty;
	logic                   full;
	logic                   enq_ok;
	logic                   deq_ok;
	logic [STATUS_W-1:0]    status_nxt;
	word_t                  value_nxt;
	logic [EXT_W-1:0]       count_ext;

	word_t                  cell_data [NCELL];
	cell_ctrl_t             cell_ctrl [NCELL];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign action        = s_axis_tuser;
	assign in_value      = word_t'(s_axis_tdata);

	assign empty = (fill_q == '0);
	assign full  = (fill_q == FILL_MAX);

	always_comb begin
		enq_ok     = 1'b0;
		deq_ok     = 1'b0;
		status_nxt = ST_OK;
		value_nxt  = '0;
		unique case (action)
			ACT_ENQ: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					enq_ok = accept;
				end
			end
			ACT_DEQ: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					deq_ok    = accept;
					value_nxt = cell_data[0];
				end
			end
			ACT_PEEK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					value_nxt = cell_data[0];
				end
			end
			default: begin
				// unused code: no operation
			end
		endcase
	end

	always_comb begin
		fill_nxt = fill_q;
		if (enq_ok) begin
			fill_nxt = fill_q + CW'(1);
		end else if (deq_ok) begin
			fill_nxt = fill_q - CW'(1);
		end
	end

	assign count_ext = EXT_W'(fill_nxt);

	genvar gi;
	generate
		for (gi = 0; gi < NCELL; gi++) begin : g_cell
			word_t upper;
			if (gi == NCELL - 1) begin : g_last
				assign upper = '0;
			end else begin : g_mid
				assign upper = cell_data[gi+1];
			end
			assign cell_ctrl[gi].shift = deq_ok;
			assign cell_ctrl[gi].load  = enq_ok && (fill_q == CW'(gi));
			cqf_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[gi]),
				.upper_data (upper),
				.in_value   (in_value),
				.data       (cell_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result of each accepted request.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			value_q  <= value_nxt;
			count_q  <= count_ext[COUNT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {4'b0000, count_q, value_q};

endmodule

FILE: rtl/cqf_checker.sv
// Port-level checks for the circular queue FIFO, bound to the top level.
module cqf_checker
	import cqf_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH - 1);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted request produced no result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
			m_axis_tuser == ST_EMPTY) && m_axis_tdata[39:36] == 4'd0)
		else $error("undefined status code or nonzero pad bits");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_FULL |->
			m_axis_tdata[35:32] == FULL_COUNT && m_axis_tdata[31:0] == 32'd0)
		else $error("full status with wrong count or value");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_EMPTY |->
			m_axis_tdata[35:32] == 4'd0 && m_axis_tdata[31:0] == 32'd0)
		else $error("empty status with nonzero count or value");

endmodule

bind circular_queue_fifo cqf_checker #(.DEPTH(DEPTH)) u_cqf_checker (.*);
